FILE: hw/rtl/vog_pkg.sv
// ----------------------------------------------------------------------------
// vog_pkg: shared types and constants for the voxel occupancy grid
// Opcode and register index codes, and the work item passed from the
// front end to the fill/query engine.
// ----------------------------------------------------------------------------
`default_nettype none

package vog_pkg;

  // Grid coordinates are carried at the widest supported grid size (1024)
  localparam int unsigned CoordW = 10;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic {
    OpMark  = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgXOrigin = 3'd0,
    CfgYOrigin = 3'd1,
    CfgZOrigin = 3'd2,
    CfgBlockX  = 3'd3,
    CfgBlockY  = 3'd4,
    CfgBlockZ  = 3'd5
  } cfg_idx_e;

  // Clipped span on one axis
  typedef struct packed {
    logic              empty;
    logic [CoordW-1:0] lo;
    logic [CoordW-1:0] hi;
  } axis_t;

  // Classified item: a query uses the lo coordinates only
  typedef struct packed {
    op_e               op;
    logic              empty;
    logic [CoordW-1:0] x_lo;
    logic [CoordW-1:0] x_hi;
    logic [CoordW-1:0] y_lo;
    logic [CoordW-1:0] y_hi;
    logic [CoordW-1:0] z_lo;
    logic [CoordW-1:0] z_hi;
  } item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vog_ram.sv
// ----------------------------------------------------------------------------
// vog_ram: generic RAM with separate write and read ports
// One write and one read per cycle, read data registered and held until
// the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module vog_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/vog_front.sv
// ----------------------------------------------------------------------------
// vog_front: configuration registers and item classification
// Subtracts the origins, clips the fill box (or the single query voxel)
// against the grid and pushes the result into the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vog_front import vog_pkg::*; #(
  parameter int unsigned GRID_X    = 128,
  parameter int unsigned GRID_Y    = 128,
  parameter int unsigned GRID_Z    = 64,
  parameter int unsigned MAX_BLOCK = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                opcode_i,
  input  wire logic signed [15:0]  x_cm_i,
  input  wire logic signed [15:0]  y_cm_i,
  input  wire logic signed [15:0]  z_cm_i,
  input  wire logic                clearing_i,
  input  wire logic                q_full_i,
  output logic                     push_o,
  output item_t                    item_o
);

  localparam logic signed [17:0] SizeX  = 18'(GRID_X);
  localparam logic signed [17:0] SizeY  = 18'(GRID_Y);
  localparam logic signed [17:0] SizeZ  = 18'(GRID_Z);
  localparam logic [4:0]         MaxBlk = 5'(MAX_BLOCK);

  logic signed [15:0] x_org_q, y_org_q, z_org_q;
  logic [3:0]         blk_x_q, blk_y_q, blk_z_q;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_org_q <= '0;
      y_org_q <= '0;
      z_org_q <= '0;
      blk_x_q <= 4'd1;
      blk_y_q <= 4'd1;
      blk_z_q <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgXOrigin: x_org_q <= cfg_wdata_i;
        CfgYOrigin: y_org_q <= cfg_wdata_i;
        CfgZOrigin: z_org_q <= cfg_wdata_i;
        CfgBlockX:  blk_x_q <= cfg_wdata_i[3:0];
        CfgBlockY:  blk_y_q <= cfg_wdata_i[3:0];
        CfgBlockZ:  blk_z_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Clip the span [d, d+ext-1] against [0, size-1]
  function automatic axis_t clip_axis(logic signed [16:0] d, logic [4:0] ext,
                                      logic signed [17:0] size);
    logic signed [17:0] lo_s;
    logic signed [17:0] hi_s;
    axis_t              r;
    lo_s = $signed({d[16], d});
    hi_s = lo_s + $signed({13'd0, ext}) - 18'sd1;
    r.empty = (ext == 5'd0) || (hi_s < 18'sd0) || (lo_s >= size);
    r.lo = (lo_s < 18'sd0) ? '0 : lo_s[CoordW-1:0];
    r.hi = (hi_s >= size) ? CoordW'(size - 18'sd1) : hi_s[CoordW-1:0];
    return r;
  endfunction

  logic signed [16:0] dx, dy, dz;
  logic [4:0]         ext_x, ext_y, ext_z;
  axis_t              ax, ay, az;
  logic               is_query;

  // Grid coordinates at full precision, no wrap
  assign dx = $signed({x_cm_i[15], x_cm_i}) - $signed({x_org_q[15], x_org_q});
  assign dy = $signed({y_cm_i[15], y_cm_i}) - $signed({y_org_q[15], y_org_q});
  assign dz = $signed({z_cm_i[15], z_cm_i}) - $signed({z_org_q[15], z_org_q});

  assign is_query = (op_e'(opcode_i) == OpQuery);

  // Box extents saturate at MAX_BLOCK; a query is a one-voxel box
  always_comb begin
    ext_x = ({1'b0, blk_x_q} > MaxBlk) ? MaxBlk : {1'b0, blk_x_q};
    ext_y = ({1'b0, blk_y_q} > MaxBlk) ? MaxBlk : {1'b0, blk_y_q};
    ext_z = ({1'b0, blk_z_q} > MaxBlk) ? MaxBlk : {1'b0, blk_z_q};
    if (is_query) begin
      ext_x = 5'd1;
      ext_y = 5'd1;
      ext_z = 5'd1;
    end
  end

  assign ax = clip_axis(dx, ext_x, SizeX);
  assign ay = clip_axis(dy, ext_y, SizeY);
  assign az = clip_axis(dz, ext_z, SizeZ);

  always_comb begin
    item_o.op    = op_e'(opcode_i);
    item_o.empty = ax.empty || ay.empty || az.empty;
    item_o.x_lo  = ax.lo;
    item_o.x_hi  = ax.hi;
    item_o.y_lo  = ay.lo;
    item_o.y_hi  = ay.hi;
    item_o.z_lo  = az.lo;
    item_o.z_hi  = az.hi;
  end

  assign in_ready_o = !clearing_i && !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;

endmodule

`default_nettype wire

FILE: hw/rtl/vog_queue.sv
// ----------------------------------------------------------------------------
// vog_queue: short work queue between front end and engine
// Two entries, so either side can stall without stopping the other.
// ----------------------------------------------------------------------------
`default_nettype none

module vog_queue import vog_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      item_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: hw/rtl/vog_back.sv
// ----------------------------------------------------------------------------
// vog_back: fill/query engine
// Clears the grid after reset, then takes classified items from the queue.
// The grid is stored one z row per RAM word; a mark does a read-modify-write
// per (x, y) row of its box, a query reads one row and picks the z bit.
// ----------------------------------------------------------------------------
`default_nettype none

module vog_back import vog_pkg::*; #(
  parameter int unsigned GRID_X = 128,
  parameter int unsigned GRID_Y = 128,
  parameter int unsigned GRID_Z = 64,
  localparam int unsigned Rows  = GRID_X * GRID_Y,
  localparam int unsigned RowW  = (Rows > 1) ? $clog2(Rows) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire item_t             q_item_i,
  output logic                   pop_o,
  output logic                   clearing_o,
  output logic                   ram_we_o,
  output logic [RowW-1:0]        ram_waddr_o,
  output logic [GRID_Z-1:0]      ram_wdata_o,
  output logic                   ram_re_o,
  output logic [RowW-1:0]        ram_raddr_o,
  input  wire logic [GRID_Z-1:0] ram_rdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   occupied_o
);

  localparam int unsigned ZW = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StRead,
    StWrite,
    StResult
  } state_e;

  state_e            state_q;
  item_t             entry_q;
  logic [CoordW-1:0] x_q, y_q;
  logic [RowW-1:0]   row_q, xbase_q;
  logic              out_valid_q, occupied_q;

  logic              slot_free;
  logic              result_set;
  logic [GRID_Z-1:0] zmask;
  logic [RowW-1:0]   head_xbase;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign head_xbase = RowW'(q_item_i.x_lo) * RowW'(GRID_Y);

  // Take an item unless it is an outside query with the result slot busy
  assign pop_o = (state_q == StIdle) && q_valid_i &&
                 !((q_item_i.op == OpQuery) && q_item_i.empty && !slot_free);

  // A query answer lands in the result register this cycle
  assign result_set = (pop_o && (q_item_i.op == OpQuery) && q_item_i.empty) ||
                      ((state_q == StResult) && slot_free);

  // z bits covered by the current box
  always_comb begin
    for (int k = 0; k < GRID_Z; k++) begin
      zmask[k] = (CoordW'(k) >= entry_q.z_lo) && (CoordW'(k) <= entry_q.z_hi);
    end
  end

  // RAM port control
  always_comb begin
    ram_we_o    = (state_q == StClear) || (state_q == StWrite);
    ram_waddr_o = row_q;
    ram_wdata_o = (state_q == StClear) ? '0 : (ram_rdata_i | zmask);
    ram_re_o    = (state_q == StRead);
    ram_raddr_o = row_q;
  end

  // Sequencer, row walk and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      entry_q     <= '0;
      x_q         <= '0;
      y_q         <= '0;
      row_q       <= '0;
      xbase_q     <= '0;
      out_valid_q <= 1'b0;
      occupied_q  <= 1'b0;
    end else begin
      if (result_set) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          row_q <= row_q + 1'b1;
          if (row_q == RowW'(Rows - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (pop_o) begin
            entry_q <= q_item_i;
            x_q     <= q_item_i.x_lo;
            y_q     <= q_item_i.y_lo;
            xbase_q <= head_xbase;
            row_q   <= head_xbase + RowW'(q_item_i.y_lo);
            if (q_item_i.empty) begin
              // fully outside: a query answers 0, a mark does nothing
              if (q_item_i.op == OpQuery) begin
                occupied_q <= 1'b0;
              end
            end else begin
              state_q <= StRead;
            end
          end
        end
        StRead: begin
          state_q <= (entry_q.op == OpQuery) ? StResult : StWrite;
        end
        StWrite: begin
          if (y_q == entry_q.y_hi) begin
            if (x_q == entry_q.x_hi) begin
              state_q <= StIdle;
            end else begin
              x_q     <= x_q + 1'b1;
              y_q     <= entry_q.y_lo;
              xbase_q <= xbase_q + RowW'(GRID_Y);
              row_q   <= xbase_q + RowW'(GRID_Y) + RowW'(entry_q.y_lo);
              state_q <= StRead;
            end
          end else begin
            y_q     <= y_q + 1'b1;
            row_q   <= row_q + 1'b1;
            state_q <= StRead;
          end
        end
        StResult: begin
          if (slot_free) begin
            occupied_q <= ram_rdata_i[entry_q.z_lo[ZW-1:0]];
            state_q    <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign clearing_o  = (state_q == StClear);
  assign out_valid_o = out_valid_q;
  assign occupied_o  = occupied_q;

endmodule

`default_nettype wire

FILE: hw/rtl/voxel_occupancy_grid_fill_query.sv
// ----------------------------------------------------------------------------
// voxel_occupancy_grid_fill_query: dense 3D occupancy grid, mark and query
// Top level: front end with configuration, work queue, engine and grid RAM.
// ----------------------------------------------------------------------------
// After reset the grid is cleared row by row while in_ready_o stays low
// (configuration writes are taken as usual). The grid lives in one RAM of
// GRID_X*GRID_Y words of GRID_Z bits, with one write port and one read port,
// and its use sets the pace: a query inside the grid is dequeued, read and
// then answered (the answer waits while the result slot is busy), a query
// outside the grid or a mark whose box misses the grid is done at dequeue,
// and a mark does a read-modify-write per (x, y) row of its clipped box,
// at most MAX_BLOCK*MAX_BLOCK rows. A two-entry queue lets the input side
// keep accepting while the engine works or a result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_occupancy_grid_fill_query import vog_pkg::*; #(
  parameter int unsigned GRID_X    = 128,
  parameter int unsigned GRID_Y    = 128,
  parameter int unsigned GRID_Z    = 64,
  parameter int unsigned MAX_BLOCK = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                opcode_i,
  input  wire logic signed [15:0]  x_cm_i,
  input  wire logic signed [15:0]  y_cm_i,
  input  wire logic signed [15:0]  z_cm_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     occupied_o
);

  localparam int unsigned Rows = GRID_X * GRID_Y;
  localparam int unsigned RowW = (Rows > 1) ? $clog2(Rows) : 1;

  logic              clearing, q_full, push, pop, q_valid;
  item_t             push_item, head_item;
  logic              ram_we, ram_re;
  logic [RowW-1:0]   ram_waddr, ram_raddr;
  logic [GRID_Z-1:0] ram_wdata, ram_rdata;

  // Front end: configuration and classification
  vog_front #(
    .GRID_X    (GRID_X),
    .GRID_Y    (GRID_Y),
    .GRID_Z    (GRID_Z),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .x_cm_i      (x_cm_i),
    .y_cm_i      (y_cm_i),
    .z_cm_i      (z_cm_i),
    .clearing_i  (clearing),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  // Work queue
  vog_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  // Engine
  vog_back #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .occupied_o  (occupied_o)
  );

  // Occupancy grid, one z row per word
  vog_ram #(
    .WIDTH (GRID_Z),
    .DEPTH (Rows)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/vog_checker.sv
// ----------------------------------------------------------------------------
// vog_checker: port-level checks for the voxel occupancy grid
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module vog_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic occupied_o
);

  // Grid clear pass runs right after reset: no beats either way
  a_clear_after_reset: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> (!in_ready_o && !out_valid_o)
  ) else $error("beat possible during grid clear pass");

  // Input side only loses ready when it takes a beat
  a_ready_sticky: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && !in_valid_i) |=> in_ready_o
  ) else $error("in_ready_o dropped without an input beat");

  // A stalled result holds
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(occupied_o))
  ) else $error("stalled result changed or dropped");

endmodule

bind voxel_occupancy_grid_fill_query vog_checker u_vog_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .occupied_o  (occupied_o)
);

`default_nettype wire

FILE: tb/occupancy_checker.sv
// ----------------------------------------------------------------------------
// occupancy_checker: shadow occupancy grid and result check
// Follows register writes and input beats to keep its own copy of the grid
// and the registers, works out the occupancy that each query should return,
// and compares every output beat with the oldest outstanding query.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_checker import vog_pkg::*; #(
  parameter int unsigned GRID_X    = 128,
  parameter int unsigned GRID_Y    = 128,
  parameter int unsigned GRID_Z    = 64,
  parameter int unsigned MAX_BLOCK = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire logic                opcode_i,
  input  wire logic signed [15:0]  x_cm_i,
  input  wire logic signed [15:0]  y_cm_i,
  input  wire logic signed [15:0]  z_cm_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire logic                occupied_i,
  output int                       error_count_o,
  output int                       pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GridX   = GRID_X;
  localparam int GridY   = GRID_Y;
  localparam int GridZ   = GRID_Z;
  localparam int MaxExt  = MAX_BLOCK;
  localparam int Voxels  = GridX * GridY * GridZ;

  // One outstanding query: predicted bit and where it looked
  typedef struct {
    logic occupied;
    int   x;
    int   y;
    int   z;
  } probe_expect_t;

  // Shadow grid; starts cleared, matching the single reset at time zero
  bit                 occupancy_shadow [Voxels];
  logic signed [15:0] x_org, y_org, z_org;
  logic [3:0]         ext_x, ext_y, ext_z;
  probe_expect_t      occupancy_expect_q [$];
  int                 errors = 0;
  int                 outstanding = 0;

  assign error_count_o = errors;
  assign pending_o     = outstanding;

  function automatic bit in_grid(int gx, int gy, int gz);
    return gx >= 0 && gx < GridX && gy >= 0 && gy < GridY && gz >= 0 && gz < GridZ;
  endfunction

  function automatic int voxel_index(int gx, int gy, int gz);
    return (gx * GridY + gy) * GridZ + gz;
  endfunction

  // Extents above the maximum saturate; zero fills nothing
  function automatic int clamp_extent(logic [3:0] e);
    return (int'(e) > MaxExt) ? MaxExt : int'(e);
  endfunction

  function automatic void fill_box(int gx, int gy, int gz);
    int bx, by, bz;
    bx = clamp_extent(ext_x);
    by = clamp_extent(ext_y);
    bz = clamp_extent(ext_z);
    for (int dx = 0; dx < bx; dx++)
      for (int dy = 0; dy < by; dy++)
        for (int dz = 0; dz < bz; dz++)
          if (in_grid(gx + dx, gy + dy, gz + dz))
            occupancy_shadow[voxel_index(gx + dx, gy + dy, gz + dz)] = 1'b1;
  endfunction

  function automatic logic probe_voxel(int gx, int gy, int gz);
    return in_grid(gx, gy, gz) ? occupancy_shadow[voxel_index(gx, gy, gz)] : 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int gx, gy, gz;
    probe_expect_t exp_beat;
    probe_expect_t got;
    if (!rst_ni) begin
      x_org <= '0;
      y_org <= '0;
      z_org <= '0;
      ext_x <= 4'd1;
      ext_y <= 4'd1;
      ext_z <= 4'd1;
    end else begin
      // Register writes; unknown indexes are dropped
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgXOrigin: x_org <= cfg_wdata_i;
          CfgYOrigin: y_org <= cfg_wdata_i;
          CfgZOrigin: z_org <= cfg_wdata_i;
          CfgBlockX:  ext_x <= cfg_wdata_i[3:0];
          CfgBlockY:  ext_y <= cfg_wdata_i[3:0];
          CfgBlockZ:  ext_z <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end

      // Output beat first: it always belongs to an earlier query
      if (out_valid_i && out_ready_i) begin
        if (occupancy_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, occupied=%0b", $realtime, occupied_i);
        end else begin
          got = occupancy_expect_q.pop_front();
          outstanding--;
          if (occupied_i !== got.occupied) begin
            errors++;
            $display("%0t: query (%0d,%0d,%0d) expected occupied=%0b, actual %0b",
                     $realtime, got.x, got.y, got.z, got.occupied, occupied_i);
          end
        end
      end

      // Input beat: grid coordinates at full precision, no wrap
      if (in_valid_i && in_ready_i) begin
        gx = int'(x_cm_i) - int'(x_org);
        gy = int'(y_cm_i) - int'(y_org);
        gz = int'(z_cm_i) - int'(z_org);
        if (opcode_i == OpMark) begin
          fill_box(gx, gy, gz);
        end else begin
          exp_beat.occupied = probe_voxel(gx, gy, gz);
          exp_beat.x = gx;
          exp_beat.y = gy;
          exp_beat.z = gz;
          occupancy_expect_q.push_back(exp_beat);
          outstanding++;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_voxel_occupancy_grid_fill_query.sv
// ----------------------------------------------------------------------------
// tb_voxel_occupancy_grid_fill_query: stimulus and verdict for the voxel grid
// Drives mark and query beats across several register settings (reset values,
// extreme origins, zero and saturating extents, random ones) with random
// gaps and output stalls; the occupancy checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_voxel_occupancy_grid_fill_query;

  timeunit 1ns;
  timeprecision 1ps;

  import vog_pkg::*;

  localparam int GridX       = 128;
  localparam int GridY       = 128;
  localparam int GridZ       = 64;
  localparam int MaxBlock    = 8;
  localparam int CycleLimit  = 2_000_000;
  localparam int SettleCycles = 500;   // > three queued full-size marks
  localparam int HoldOffCycles = 400;
  localparam logic [CfgIdxW-1:0] RegIdxSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] RegIdxSpareB = 3'd7;

  typedef struct {
    int x;
    int y;
    int z;
  } grid_pt_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                opcode = 1'b0;
  logic signed [15:0]  x_cm = '0;
  logic signed [15:0]  y_cm = '0;
  logic signed [15:0]  z_cm = '0;
  logic                out_ready = 1'b0;
  wire logic           in_ready;
  wire logic           out_valid;
  wire logic           occupied;
  int                  mismatches;
  int                  pending;
  int                  cycle_count = 0;
  bit                  hold_req = 1'b0;
  int                  cur_xo = 0, cur_yo = 0, cur_zo = 0;
  grid_pt_t            recent_marks [$];

  voxel_occupancy_grid_fill_query #(
    .GRID_X   (GridX),
    .GRID_Y   (GridY),
    .GRID_Z   (GridZ),
    .MAX_BLOCK(MaxBlock)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .opcode_i   (opcode),
    .x_cm_i     (x_cm),
    .y_cm_i     (y_cm),
    .z_cm_i     (z_cm),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .occupied_o (occupied)
  );

  occupancy_checker #(
    .GRID_X   (GridX),
    .GRID_Y   (GridY),
    .GRID_Z   (GridZ),
    .MAX_BLOCK(MaxBlock)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .opcode_i     (opcode),
    .x_cm_i       (x_cm),
    .y_cm_i       (y_cm),
    .z_cm_i       (z_cm),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .occupied_i   (occupied),
    .error_count_o(mismatches),
    .pending_o    (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly zero, sometimes short, rarely long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, long runs without any, and a hold-off on request
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                          : $urandom_range(1, 12)) @(posedge clk_i);
      out_ready <= 1'b0;
      repeat (idle_len() + 1) @(posedge clk_i);
    end
  end

  // One input beat; valid only drops when a gap is wanted
  task automatic send_beat(op_e op, int xc, int yc, int zc, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    x_cm     <= 16'(xc);
    y_cm     <= 16'(yc);
    z_cm     <= 16'(zc);
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Coordinates given relative to the current origin
  task automatic send_grid(op_e op, int gx, int gy, int gz, int gap);
    send_beat(op, cur_xo + gx, cur_yo + gy, cur_zo + gz, gap);
  endtask

  task automatic send_random(int gap);
    op_e      op;
    int       r;
    grid_pt_t p;
    op = ($urandom_range(0, 99) < 40) ? OpMark : OpQuery;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      // noise anywhere in the coordinate space
      send_beat(op, $urandom, $urandom, $urandom, gap);
    end else begin
      if (op == OpQuery && recent_marks.size() > 0 && r < 70) begin
        p = recent_marks[$urandom_range(0, recent_marks.size() - 1)];
        p.x += int'($urandom_range(0, 9)) - 1;
        p.y += int'($urandom_range(0, 9)) - 1;
        p.z += int'($urandom_range(0, 9)) - 1;
      end else begin
        // near and across the grid faces
        p.x = int'($urandom_range(0, GridX + 11)) - 8;
        p.y = int'($urandom_range(0, GridY + 11)) - 8;
        p.z = int'($urandom_range(0, GridZ + 11)) - 8;
      end
      send_grid(op, p.x, p.y, p.z, gap);
      if (op == OpMark) begin
        recent_marks.push_back(p);
        if (recent_marks.size() > 16) void'(recent_marks.pop_front());
      end
    end
  endtask

  // Random beats; optional receiver hold-off with back-to-back beats
  task automatic run_random(int count, bit with_hold);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 3) begin
        // idle until the receiver has started holding off
        in_valid <= 1'b0;
        hold_req = 1'b1;
        wait (!hold_req);
        repeat (15) send_random(0);
      end
      if (i >= count / 2 && i < count / 2 + 20) send_random(0);
      else send_random(idle_len());
    end
  endtask

  // Wait for all results, then let any trailing mark finish
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // All six registers, then junk to the unused indexes
  task automatic load_registers(int xo, int yo, int zo, int bx, int by, int bz);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgXOrigin;
    cfg_wdata <= 16'(xo);
    @(posedge clk_i);
    cfg_idx   <= CfgYOrigin;
    cfg_wdata <= 16'(yo);
    @(posedge clk_i);
    cfg_idx   <= CfgZOrigin;
    cfg_wdata <= 16'(zo);
    @(posedge clk_i);
    cfg_idx   <= CfgBlockX;
    cfg_wdata <= {12'($urandom), 4'(bx)};
    @(posedge clk_i);
    cfg_idx   <= CfgBlockY;
    cfg_wdata <= {12'($urandom), 4'(by)};
    @(posedge clk_i);
    cfg_idx   <= CfgBlockZ;
    cfg_wdata <= {12'($urandom), 4'(bz)};
    @(posedge clk_i);
    cfg_idx   <= RegIdxSpareA;
    cfg_wdata <= 16'($urandom);
    @(posedge clk_i);
    cfg_idx   <= RegIdxSpareB;
    cfg_wdata <= 16'($urandom);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_xo = xo;
    cur_yo = yo;
    cur_zo = zo;
  endtask

  function automatic int rand_origin();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rand_extent();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 15);
  endfunction

  // Stimulus
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: unit extents, zero origins; cleared grid, corners, faces
    send_beat(OpQuery, 0, 0, 0, 0);
    send_beat(OpMark, 0, 0, 0, idle_len());
    send_beat(OpQuery, 0, 0, 0, 0);
    send_beat(OpQuery, 0, 0, 1, 0);
    send_beat(OpQuery, 1, 0, 0, idle_len());
    send_beat(OpMark, 127, 127, 63, 0);
    send_beat(OpQuery, 127, 127, 63, 0);
    send_beat(OpQuery, 128, 127, 63, idle_len());
    send_beat(OpQuery, 127, 128, 63, 0);
    send_beat(OpQuery, 127, 127, 64, 0);
    send_beat(OpQuery, -1, 0, 0, 0);
    send_beat(OpQuery, 0, -1, 0, idle_len());
    send_beat(OpQuery, 0, 0, -1, 0);
    send_beat(OpMark, -1, -1, -1, 0);
    send_beat(OpQuery, 32767, 32767, 32767, 0);
    send_beat(OpQuery, -32768, -32768, -32768, idle_len());
    send_beat(OpMark, 32767, -32768, 32767, 0);
    send_beat(OpMark, 5, 6, 7, 0);
    send_beat(OpQuery, 5, 6, 7, 0);
    send_beat(OpQuery, 6, 6, 7, 0);
    run_random(50, 1'b1);

    // Lowest origins, full-size boxes, boxes hanging over the faces
    settle();
    load_registers(-32768, -32768, -32768, 8, 8, 8);
    send_grid(OpMark, -4, -4, -4, 0);
    send_grid(OpQuery, 0, 0, 0, 0);
    send_grid(OpQuery, 3, 3, 3, 0);
    send_grid(OpQuery, 4, 4, 4, 0);
    send_grid(OpMark, 124, 124, 60, idle_len());
    send_grid(OpQuery, 127, 127, 63, 0);
    send_grid(OpQuery, 123, 124, 60, 0);
    run_random(50, 1'b0);

    // Highest origins, extents beyond the maximum
    settle();
    load_registers(32767, 32767, 32767, 15, 15, 15);
    send_beat(OpMark, 32767, 32767, 32767, 0);
    send_beat(OpQuery, 32767, 32767, 32767, 0);
    run_random(20, 1'b0);

    // A zero extent fills nothing
    settle();
    load_registers(int'($urandom_range(0, 200)) - 100, int'($urandom_range(0, 200)) - 100,
                   int'($urandom_range(0, 200)) - 100, 1, 0, 5);
    send_grid(OpMark, 10, 10, 10, 0);
    send_grid(OpQuery, 10, 10, 10, 0);
    run_random(20, 1'b0);

    settle();
    load_registers(rand_origin(), rand_origin(), rand_origin(), 2, 3, 15);
    run_random(70, 1'b1);

    repeat (3) begin
      settle();
      load_registers(rand_origin(), rand_origin(), rand_origin(),
                     rand_extent(), rand_extent(), rand_extent());
      run_random(65, 1'b0);
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
